// ===== hdl/css_pkg.sv =====
// css_pkg: shared types and defaults for the cursor sequence store
// operation kinds, result status codes and cell shift modes
// depends on nothing; used by css_cell and cursor_sequence_store
package css_pkg;

	localparam int DEPTH_DEFAULT      = 32;
	localparam int DATA_WIDTH_DEFAULT = 32;

	// operation selector carried in s_tuser
	typedef enum logic [2:0] {
		KIND_START   = 3'd0,
		KIND_ADVANCE = 3'd1,
		KIND_INSERT  = 3'd2,
		KIND_ATTACH  = 3'd3,
		KIND_REMOVE  = 3'd4
	} kind_t;

	// result status
	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_FULL       = 2'd1,
		ST_NO_CURRENT = 2'd2
	} status_t;

	// what the row of cells does this cycle
	typedef enum logic [1:0] {
		MODE_HOLD   = 2'd0,
		MODE_INSERT = 2'd1,
		MODE_REMOVE = 2'd2
	} shift_mode_t;

endpackage

// ===== hdl/css_cell.sv =====
// css_cell: one storage slot of the sequence row
// shifts up from its lower neighbour on insert, down from its upper one on remove
// depends on css_pkg
module css_cell #(
	parameter int DW    = css_pkg::DATA_WIDTH_DEFAULT,
	parameter int PW    = 5,
	parameter int INDEX = 0
) (
	input  logic                     clk,
	input  css_pkg::shift_mode_t     mode,
	input  logic [PW-1:0]            pos,
	input  logic [DW-1:0]            load_value,
	input  logic [DW-1:0]            prev_data,
	input  logic [DW-1:0]            next_data,
	input  logic [PW-1:0]            cursor_pos,
	input  logic                     cursor_valid,
	output logic [DW-1:0]            data,
	output logic [DW-1:0]            tap
);

	localparam logic [PW-1:0] MY_INDEX = PW'(INDEX);

	logic [DW-1:0] data_q;
	logic [DW-1:0] data_d;

	// pick the new contents from the shared shift command
	always_comb begin
		data_d = data_q;
		case (mode)
			css_pkg::MODE_INSERT: begin
				if (MY_INDEX == pos) begin
					data_d = load_value;
				end else if (MY_INDEX > pos) begin
					data_d = prev_data;
				end
			end
			css_pkg::MODE_REMOVE: begin
				if (MY_INDEX >= pos) begin
					data_d = next_data;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

	// contribute to the cursor read only when this slot is current
	assign tap = (cursor_valid && (cursor_pos == MY_INDEX)) ? data_q : '0;

endmodule

// ===== hdl/cursor_sequence_store.sv =====
// cursor_sequence_store: ordered store of values with a cursor, built as a row of cells
// one operation per input beat, one result beat per operation
// depends on css_pkg and css_cell
//
// Each accepted beat carries an operation in s_tuser (start, advance, insert, attach,
// remove) and a value in s_tdata. The cells update in the accept cycle, with every
// entry above the affected position moving one cell in a single shift; once the
// output register is free, the entry under the cursor is gathered from the row into it.
// No new beat is taken until that gather step has moved the last result out; a result
// waiting on m_tready stalls the input only once the following result is ready. Full
// store or a missing cursor give an error status and leave the store untouched.
module cursor_sequence_store #(
	parameter int DEPTH      = css_pkg::DEPTH_DEFAULT,
	parameter int DATA_WIDTH = css_pkg::DATA_WIDTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // entry_value[31:0]
	input  logic [2:0]  s_tuser,  // kind[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // current_value[31:0], has_current[32],
	                              // item_count[38:33], status[40:39], zero[47:41]
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	logic [CW-1:0] count_q, count_d;
	logic [PW-1:0] pos_q, pos_d;
	logic          cur_valid_q, cur_valid_d;
	logic          pend_q;
	css_pkg::status_t status_q, status_d;

	logic          out_valid_q;
	logic [31:0]   out_value_q;
	logic          out_has_q;
	logic [5:0]    out_count_q;
	css_pkg::status_t out_status_q;

	css_pkg::shift_mode_t mode;
	logic [PW-1:0]        shift_pos;
	logic [DATA_WIDTH-1:0] in_value;
	logic [63:0]          in_wide;
	logic                 accept;
	logic                 move_out;

	logic [DATA_WIDTH-1:0] cell_data [DEPTH];
	logic [DATA_WIDTH-1:0] cell_tap  [DEPTH];
	logic [DATA_WIDTH-1:0] cur_sel;
	logic [63:0]           cur_wide;
	logic [5:0]            count_wide;

	assign s_tready = !pend_q;
	assign accept   = s_tvalid && s_tready;
	assign move_out = pend_q && (!out_valid_q || m_tready);

	// mask the incoming value to the stored width
	assign in_wide  = {32'd0, s_tdata};
	assign in_value = in_wide[DATA_WIDTH-1:0];

	// decode the operation into the next cursor state and a shift command
	always_comb begin
		count_d     = count_q;
		pos_d       = pos_q;
		cur_valid_d = cur_valid_q;
		status_d    = css_pkg::ST_OK;
		mode        = css_pkg::MODE_HOLD;
		shift_pos   = pos_q;
		if (accept) begin
			case (css_pkg::kind_t'(s_tuser))
				css_pkg::KIND_START: begin
					if (count_q != '0) begin
						pos_d       = '0;
						cur_valid_d = 1'b1;
					end
				end
				css_pkg::KIND_ADVANCE: begin
					if (!cur_valid_q) begin
						status_d = css_pkg::ST_NO_CURRENT;
					end else if ((CW'(pos_q) + CW'(1)) >= count_q) begin
						cur_valid_d = 1'b0;
					end else begin
						pos_d = pos_q + PW'(1);
					end
				end
				css_pkg::KIND_INSERT: begin
					if (count_q >= FULL_COUNT) begin
						status_d = css_pkg::ST_FULL;
					end else begin
						shift_pos   = cur_valid_q ? pos_q : '0;
						mode        = css_pkg::MODE_INSERT;
						count_d     = count_q + CW'(1);
						pos_d       = shift_pos;
						cur_valid_d = 1'b1;
					end
				end
				css_pkg::KIND_ATTACH: begin
					if (count_q >= FULL_COUNT) begin
						status_d = css_pkg::ST_FULL;
					end else begin
						shift_pos   = cur_valid_q ? (pos_q + PW'(1)) : count_q[PW-1:0];
						mode        = css_pkg::MODE_INSERT;
						count_d     = count_q + CW'(1);
						pos_d       = shift_pos;
						cur_valid_d = 1'b1;
					end
				end
				css_pkg::KIND_REMOVE: begin
					if (!cur_valid_q) begin
						status_d = css_pkg::ST_NO_CURRENT;
					end else begin
						mode      = css_pkg::MODE_REMOVE;
						shift_pos = pos_q;
						count_d   = count_q - CW'(1);
						if ((CW'(pos_q) + CW'(1)) >= count_q) begin
							cur_valid_d = 1'b0;
						end
					end
				end
				default: begin
					status_d = css_pkg::ST_OK;
				end
			endcase
		end
	end

	// cursor, count and pending-result control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pos_q       <= '0;
			cur_valid_q <= 1'b0;
			pend_q      <= 1'b0;
			status_q    <= css_pkg::ST_OK;
		end else begin
			count_q     <= count_d;
			pos_q       <= pos_d;
			cur_valid_q <= cur_valid_d;
			if (accept) begin
				pend_q   <= 1'b1;
				status_q <= status_d;
			end else if (move_out) begin
				pend_q <= 1'b0;
			end
		end
	end

	// row of cells, each linked to both neighbours
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] prev_d;
		logic [DATA_WIDTH-1:0] next_d;
		if (i == 0) begin : g_first
			assign prev_d = '0;
		end else begin : g_prev
			assign prev_d = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next_d = '0;
		end else begin : g_next
			assign next_d = cell_data[i+1];
		end
		css_cell #(
			.DW    (DATA_WIDTH),
			.PW    (PW),
			.INDEX (i)
		) u_cell (
			.clk          (clk),
			.mode         (mode),
			.pos          (shift_pos),
			.load_value   (in_value),
			.prev_data    (prev_d),
			.next_data    (next_d),
			.cursor_pos   (pos_q),
			.cursor_valid (cur_valid_q),
			.data         (cell_data[i]),
			.tap          (cell_tap[i])
		);
	end

	// gather the current entry: at most one tap is non-zero
	always_comb begin
		cur_sel = '0;
		for (int i = 0; i < DEPTH; i++) begin
			cur_sel = cur_sel | cell_tap[i];
		end
	end

	assign cur_wide   = 64'(cur_sel);
	assign count_wide = 6'(count_q);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_out) begin
			out_value_q  <= cur_wide[31:0];
			out_has_q    <= cur_valid_q;
			out_count_q  <= count_wide;
			out_status_q <= status_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_status_q, out_count_q, out_has_q, out_value_q};

`ifndef SYNTHESIS
	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> (CW'(pos_q) < count_q))
		else $error("cursor beyond the stored entries");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("entry count above depth");

	a_accept_pends: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (pend_q && !s_tready))
		else $error("accepted beat left no pending result");

	a_error_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (status_d != css_pkg::ST_OK)) |=>
		($stable(count_q) && $stable(pos_q) && $stable(cur_valid_q)))
		else $error("failed operation changed the store");
`endif

endmodule
